[rtl/text_console_cursor_writer_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for text_console_cursor_writer_top
// Clocked concurrent assertions, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_WRITER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TCCW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TCCW_ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) not (prop)) else $error(msg);
`else
`define TCCW_ASSERT(lbl, clk, rstn, prop, msg)
`define TCCW_ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif

`endif

[rtl/tccw_pkg.sv]
// ----------------------------------------------------------------------------
// tccw_pkg
// Types and constants shared by the text console cursor writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 6;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CDATA_W = 7;

  localparam logic [COL_W-1:0]   LINE_WIDTH_RST = 7'd80;
  localparam logic [ROW_W-1:0]   BOTTOM_ROW_RST = 6'd49;
  localparam logic [CHAR_W-1:0]  NEWLINE_CODE   = 8'd10;

  localparam logic [CIDX_W-1:0]  CFG_IDX_LINE_WIDTH = 2'd0;
  localparam logic [CIDX_W-1:0]  CFG_IDX_BOTTOM_ROW = 2'd1;

  typedef enum logic [1:0] {
    KIND_PUT      = 2'd0,
    KIND_NEXT_ROW = 2'd1,
    KIND_SCROLL   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last_byte;
  } char_t;

  typedef struct packed {
    kind_e             kind;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [CHAR_W-1:0] glyph;
    logic              last_of_run;
    logic              write_done;
  } op_t;

  typedef struct packed {
    logic [CIDX_W-1:0]  index;
    logic [CDATA_W-1:0] value;
  } cfg_t;

  typedef struct packed {
    logic              put;
    logic [CHAR_W-1:0] glyph;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W-1:0]  put_row;
    logic              line_end;
    logic              scroll;
    logic [ROW_W-1:0]  end_row;
    logic              last_byte;
  } entry_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
  } cursor_t;

endpackage

`default_nettype wire

[rtl/tccw_chan_if.sv]
// ----------------------------------------------------------------------------
// tccw_chan_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tccw_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

[rtl/tccw_front.sv]
// ----------------------------------------------------------------------------
// tccw_front
// Takes character bytes, tracks the cursor and classifies each byte into a
// queue entry; holds the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  tccw_chan_if.sink            char_i,
  tccw_chan_if.sink            cfg_i,
  output tccw_pkg::entry_t     entry_o,
  output logic                 push_o,
  input  wire logic            full_i,
  output tccw_pkg::cursor_t    cursor_o
);

  logic [tccw_pkg::COL_W-1:0] line_width_q;
  logic [tccw_pkg::ROW_W-1:0] bottom_row_q;
  logic [tccw_pkg::COL_W-1:0] col_q, col_d;
  logic [tccw_pkg::ROW_W-1:0] row_q, row_d;
  logic [tccw_pkg::COL_W:0]   next_col;
  logic                       is_nl;
  logic                       wrap;
  logic                       line_end;
  logic                       scroll;
  logic [tccw_pkg::ROW_W-1:0] end_row;
  logic                       accept;

  assign char_i.ready = !full_i;
  assign cfg_i.ready  = 1'b1;
  assign accept       = char_i.valid && !full_i;
  assign push_o       = accept;
  assign cursor_o     = '{column: col_q, row: row_q};

  always_comb begin
    is_nl    = char_i.data.character == tccw_pkg::NEWLINE_CODE;
    next_col = {1'b0, col_q} + 8'd1;
    wrap     = !is_nl && (next_col >= {1'b0, line_width_q});
    line_end = is_nl || wrap;
    scroll   = row_q >= bottom_row_q;
    end_row  = scroll ? row_q : row_q + 6'd1;
    col_d    = line_end ? '0 : next_col[tccw_pkg::COL_W-1:0];
    row_d    = line_end ? end_row : row_q;

    entry_o.put       = !is_nl;
    entry_o.glyph     = char_i.data.character;
    entry_o.put_col   = col_q;
    entry_o.put_row   = row_q;
    entry_o.line_end  = line_end;
    entry_o.scroll    = scroll;
    entry_o.end_row   = end_row;
    entry_o.last_byte = char_i.data.last_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      line_width_q <= tccw_pkg::LINE_WIDTH_RST;
      bottom_row_q <= tccw_pkg::BOTTOM_ROW_RST;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (cfg_i.valid) begin
        unique case (cfg_i.data.index)
          tccw_pkg::CFG_IDX_LINE_WIDTH: begin
            line_width_q <= cfg_i.data.value;
          end
          tccw_pkg::CFG_IDX_BOTTOM_ROW: begin
            bottom_row_q <= cfg_i.data.value[tccw_pkg::ROW_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[rtl/tccw_fifo.sv]
// ----------------------------------------------------------------------------
// tccw_fifo
// Short queue of classified entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire tccw_pkg::entry_t entry_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output tccw_pkg::entry_t      entry_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tccw_pkg::entry_t  mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

[rtl/tccw_back.sv]
// ----------------------------------------------------------------------------
// tccw_back
// Expands each queue entry into its put and line-end results and drives the
// registered output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tccw_pkg::entry_t  entry_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  tccw_chan_if.source            op_o
);

  logic             valid_q, valid_d;
  logic             phase_q, phase_d;
  tccw_pkg::op_t    op_q, op_d;
  tccw_pkg::op_t    put_op, end_op;
  logic             load;

  assign op_o.valid = valid_q;
  assign op_o.data  = op_q;

  always_comb begin
    put_op.kind        = tccw_pkg::KIND_PUT;
    put_op.column      = entry_i.put_col;
    put_op.row         = entry_i.put_row;
    put_op.glyph       = entry_i.glyph;
    put_op.last_of_run = !entry_i.line_end;
    put_op.write_done  = !entry_i.line_end && entry_i.last_byte;

    end_op.kind        = entry_i.scroll ? tccw_pkg::KIND_SCROLL : tccw_pkg::KIND_NEXT_ROW;
    end_op.column      = '0;
    end_op.row         = entry_i.end_row;
    end_op.glyph       = '0;
    end_op.last_of_run = 1'b1;
    end_op.write_done  = entry_i.last_byte;

    load    = !valid_q || op_o.ready;
    valid_d = valid_q;
    phase_d = phase_q;
    op_d    = op_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        if (entry_i.put && !phase_q) begin
          op_d    = put_op;
          phase_d = entry_i.line_end;
          pop_o   = !entry_i.line_end;
        end else begin
          op_d    = end_op;
          phase_d = 1'b0;
          pop_o   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

endmodule

`default_nettype wire

[rtl/text_console_cursor_writer_top.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_writer_top
// Cursor tracking for a text screen: turns character bytes into put, next-row
// and scroll operations.
//
//   Channel  Dir  Payload                                         Role
//   char_i   in   character, last_byte                            bytes to show
//   cfg_i    in   index, value                                    register write
//   op_o     out  kind, column, row, glyph, last_of_run, write_done  display ops
//
// One byte is taken per cycle while the entry queue has room; cursor update
// is done in the cycle of the transfer.
// Results leave via an output register, one per cycle while op_o is ready;
// a byte that wraps gives two results, so wrapping runs are output-paced.
// Reset clears the cursor to 0,0 and loads line width 80, bottom row 49.
// A stalled output fills the queue (QUEUE_DEPTH entries), then holds char_i.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_cursor_writer_top_defines.svh"

module text_console_cursor_writer_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tccw_chan_if.sink   char_i,
  tccw_chan_if.sink   cfg_i,
  tccw_chan_if.source op_o
);

  tccw_pkg::entry_t  push_entry;
  tccw_pkg::entry_t  head_entry;
  tccw_pkg::cursor_t cursor;
  logic              push;
  logic              full;
  logic              pop;
  logic              empty;

  tccw_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_i),
    .cfg_i    (cfg_i),
    .entry_o  (push_entry),
    .push_o   (push),
    .full_i   (full),
    .cursor_o (cursor)
  );

  tccw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (empty)
  );

  tccw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .op_o    (op_o)
  );

  `TCCW_ASSERT(a_newline_home, clk_i, rst_ni, (char_i.valid && char_i.ready && char_i.data.character == tccw_pkg::NEWLINE_CODE) |=> (cursor.column == '0), "newline did not return column to 0")
  `TCCW_ASSERT(a_line_end_clean, clk_i, rst_ni, (op_o.valid && op_o.data.kind != tccw_pkg::KIND_PUT) |-> (op_o.data.column == '0 && op_o.data.glyph == '0 && op_o.data.last_of_run), "line-end result carries column, glyph or misses run end")
  `TCCW_ASSERT_NEVER(a_done_on_last, clk_i, rst_ni, op_o.valid && op_o.data.write_done && !op_o.data.last_of_run, "write_done outside last result of run")

endmodule

`default_nettype wire

[tb/text_console_cursor_writer_top_test.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_writer_top_test
// Drives character bytes and register writes into the cursor writer, keeps an
// own cursor and register mirror to forecast every display operation, and
// checks each op transfer field by field under random idling and long stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_writer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned HOLD_LEN     = 200;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [tccw_pkg::CIDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [tccw_pkg::CIDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  typedef logic [tccw_pkg::CHAR_W-1:0]  byte_val_t;
  typedef logic [tccw_pkg::COL_W-1:0]   col_val_t;
  typedef logic [tccw_pkg::ROW_W-1:0]   row_val_t;
  typedef logic [tccw_pkg::CDATA_W-1:0] cdata_val_t;

  logic clk_i;
  logic rst_ni;

  tccw_chan_if #(.payload_t(tccw_pkg::char_t)) char_if ();
  tccw_chan_if #(.payload_t(tccw_pkg::cfg_t))  cfg_if ();
  tccw_chan_if #(.payload_t(tccw_pkg::op_t))   op_if ();

  text_console_cursor_writer_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .cfg_i  (cfg_if),
    .op_o   (op_if)
  );

  col_val_t         line_width_q;
  row_val_t         bottom_row_q;
  col_val_t         cursor_col_q;
  row_val_t         cursor_row_q;
  tccw_pkg::op_t    pending_ops[$];

  bit          no_idle;
  int unsigned hold_reqs;
  int unsigned holds_served;
  int unsigned hold_left;

  int unsigned bytes_sent;
  int unsigned reg_writes;
  int unsigned puts_seen;
  int unsigned rows_seen;
  int unsigned scrolls_seen;
  int unsigned mismatches;
  int unsigned strays;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- forecast
  task automatic end_line(input logic last);
    tccw_pkg::op_t op;
    if (cursor_row_q >= bottom_row_q) begin
      op.kind = tccw_pkg::KIND_SCROLL;
    end else begin
      cursor_row_q = cursor_row_q + 1'b1;
      op.kind = tccw_pkg::KIND_NEXT_ROW;
    end
    cursor_col_q   = '0;
    op.column      = '0;
    op.row         = cursor_row_q;
    op.glyph       = '0;
    op.last_of_run = 1'b1;
    op.write_done  = last;
    pending_ops.push_back(op);
  endtask

  task automatic forecast_ops(input tccw_pkg::char_t c);
    tccw_pkg::op_t op;
    int unsigned   nxt;
    if (c.character == tccw_pkg::NEWLINE_CODE) begin
      end_line(c.last_byte);
    end else begin
      op.kind        = tccw_pkg::KIND_PUT;
      op.column      = cursor_col_q;
      op.row         = cursor_row_q;
      op.glyph       = c.character;
      op.last_of_run = 1'b0;
      op.write_done  = 1'b0;
      nxt = cursor_col_q + 1;
      if (nxt >= line_width_q) begin
        pending_ops.push_back(op);
        end_line(c.last_byte);
      end else begin
        cursor_col_q   = nxt[tccw_pkg::COL_W-1:0];
        op.last_of_run = 1'b1;
        op.write_done  = c.last_byte;
        pending_ops.push_back(op);
      end
    end
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic send_char(input byte_val_t ch, input logic last);
    tccw_pkg::char_t c;
    c.character = ch;
    c.last_byte = last;
    while (!no_idle && $urandom_range(99) < 24) begin
      @(negedge clk_i);
      char_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    char_if.valid <= 1'b1;
    char_if.data  <= c;
    do @(posedge clk_i); while (!char_if.ready);
    forecast_ops(c);
    bytes_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    char_if.valid <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tccw_pkg::CIDX_W-1:0] idx, input cdata_val_t value);
    tccw_pkg::cfg_t w;
    w.index = idx;
    w.value = value;
    wait_drain();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == tccw_pkg::CFG_IDX_LINE_WIDTH) line_width_q = value;
    else if (idx == tccw_pkg::CFG_IDX_BOTTOM_ROW) bottom_row_q = value[tccw_pkg::ROW_W-1:0];
    reg_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // receiver: random idling plus requested long hold-offs
  initial begin
    op_if.ready = 1'b0;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        op_if.ready <= 1'b0;
      end else if (holds_served != hold_reqs) begin
        holds_served++;
        hold_left = HOLD_LEN - 1;
        op_if.ready <= 1'b0;
      end else begin
        op_if.ready <= no_idle || ($urandom_range(99) >= 24);
      end
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk_i) begin
    tccw_pkg::op_t want;
    tccw_pkg::op_t got;
    if (rst_ni && op_if.valid && op_if.ready) begin
      got = op_if.data;
      case (got.kind)
        tccw_pkg::KIND_PUT:      puts_seen++;
        tccw_pkg::KIND_NEXT_ROW: rows_seen++;
        default:                 scrolls_seen++;
      endcase
      if (pending_ops.size() == 0) begin
        strays++;
        if (mismatches + strays <= MAX_REPORTS)
          $display("unexpected op at %0t: kind %0d col %0d row %0d glyph %0h",
                   $realtime, got.kind, got.column, got.row, got.glyph);
      end else begin
        want = pending_ops.pop_front();
        if (got.kind !== want.kind || got.column !== want.column ||
            got.row !== want.row || got.glyph !== want.glyph ||
            got.last_of_run !== want.last_of_run ||
            got.write_done !== want.write_done) begin
          mismatches++;
          if (mismatches + strays <= MAX_REPORTS) begin
            $display("op mismatch at %0t", $realtime);
            $display("  expected kind %0d col %0d row %0d glyph %0h last %0b done %0b",
                     want.kind, want.column, want.row, want.glyph,
                     want.last_of_run, want.write_done);
            $display("  actual   kind %0d col %0d row %0d glyph %0h last %0b done %0b",
                     got.kind, got.column, got.row, got.glyph,
                     got.last_of_run, got.write_done);
          end
        end
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((char_if.valid && char_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (op_if.valid && op_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- tests
  task automatic test_reset_defaults();
    send_char(8'h41, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(tccw_pkg::NEWLINE_CODE, 1'b1);
    send_char(8'h20, 1'b1);
  endtask

  task automatic test_narrow_lines();
    write_reg(tccw_pkg::CFG_IDX_LINE_WIDTH, 7'd1);
    send_char(8'h61, 1'b0);
    send_char(8'h62, 1'b1);
    write_reg(tccw_pkg::CFG_IDX_LINE_WIDTH, 7'd0);
    send_char(8'h7E, 1'b1);
    send_char(8'h80, 1'b0);
  endtask

  task automatic test_width_lowered();
    write_reg(tccw_pkg::CFG_IDX_LINE_WIDTH, 7'd127);
    repeat (8) send_char(byte_val_t'(8'h30 + $urandom_range(9)), 1'b0);
    write_reg(tccw_pkg::CFG_IDX_LINE_WIDTH, 7'd3);
    send_char(8'h5A, 1'b1);
  endtask

  task automatic test_bottom_row();
    write_reg(tccw_pkg::CFG_IDX_BOTTOM_ROW, 7'd0);
    send_char(tccw_pkg::NEWLINE_CODE, 1'b0);
    send_char(8'h21, 1'b1);
    write_reg(tccw_pkg::CFG_IDX_BOTTOM_ROW, 7'h7F);
    write_reg(CFG_IDX_SPARE_A, 7'h7F);
    write_reg(CFG_IDX_SPARE_B, 7'h00);
    send_char(tccw_pkg::NEWLINE_CODE, 1'b1);
  endtask

  task automatic run_text_phase(input col_val_t lw, input row_val_t br,
                                input int unsigned n, input int unsigned nl_pct);
    int unsigned r;
    byte_val_t   ch;
    write_reg(tccw_pkg::CFG_IDX_LINE_WIDTH, lw);
    write_reg(tccw_pkg::CFG_IDX_BOTTOM_ROW, {1'b0, br});
    if ($urandom_range(2) == 0)
      write_reg(($urandom_range(1) != 0) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                cdata_val_t'($urandom_range(127)));
    repeat (n) begin
      r = $urandom_range(99);
      if (r < nl_pct) ch = tccw_pkg::NEWLINE_CODE;
      else if (r < 85) ch = byte_val_t'($urandom_range(8'h7E, 8'h20));
      else ch = byte_val_t'($urandom_range(255));
      send_char(ch, $urandom_range(7) == 0);
    end
  endtask

  task automatic test_random_text();
    run_text_phase(7'd127, 6'd63, 350, 1);
    no_idle = 1'b1;
    run_text_phase(7'd4, 6'd63, 250, 10);
    no_idle = 1'b0;
    run_text_phase(7'd1, 6'd0, 150, 5);
    run_text_phase(7'd0, 6'd10, 100, 5);
    run_text_phase(tccw_pkg::LINE_WIDTH_RST, tccw_pkg::BOTTOM_ROW_RST, 200, 4);
    repeat (3) run_text_phase(col_val_t'($urandom_range(127)), row_val_t'($urandom_range(63)),
                              80, $urandom_range(20));
  endtask

  task automatic test_backpressure();
    write_reg(tccw_pkg::CFG_IDX_LINE_WIDTH, 7'd2);
    write_reg(tccw_pkg::CFG_IDX_BOTTOM_ROW, 7'd5);
    no_idle = 1'b1;
    hold_reqs++;
    repeat (40) send_char(byte_val_t'($urandom_range(255)), $urandom_range(1) != 0);
    no_idle = 1'b0;
    wait_drain();
    repeat (20) send_char(byte_val_t'($urandom_range(255)), $urandom_range(1) != 0);
  endtask

  initial begin
    int unsigned failures;
    rst_ni        = 1'b0;
    char_if.valid = 1'b0;
    char_if.data  = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    no_idle       = 1'b0;
    hold_reqs     = 0;
    bytes_sent = 0; reg_writes = 0; puts_seen = 0; rows_seen = 0; scrolls_seen = 0;
    mismatches = 0; strays = 0;
    line_width_q = tccw_pkg::LINE_WIDTH_RST;
    bottom_row_q = tccw_pkg::BOTTOM_ROW_RST;
    cursor_col_q = '0;
    cursor_row_q = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_narrow_lines();
    test_width_lowered();
    test_bottom_row();
    test_random_text();
    test_backpressure();

    wait_drain();
    failures = mismatches + strays + pending_ops.size();
    $display("Covered %0d bytes, %0d register writes", bytes_sent, reg_writes);
    $display("Ops seen: %0d puts, %0d row advances, %0d scrolls; widths 0..127, long stalls",
             puts_seen, rows_seen, scrolls_seen);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl
rtl/tccw_pkg.sv
rtl/tccw_chan_if.sv
rtl/tccw_front.sv
rtl/tccw_fifo.sv
rtl/tccw_back.sv
rtl/text_console_cursor_writer_top.sv
tb/text_console_cursor_writer_top_test.sv
